>>> rtl/core/siq_pkg.sv
// Shared types, constants and codes for the sorted insert queue.
package siq_pkg;

    localparam int LIST_DEPTH  = 16;
    localparam int HANDLE_BITS = 8;
    localparam int KEY_W       = 32;
    localparam int HANDLE_W    = 8;   // width of the handle fields on the ports
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_DUMP
    } siq_state_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                   capture;    // latch the per-cell mark
        logic                   cap_insert; // mark is an insert hit, else a handle match
        logic                   desc;       // descending order
        logic                   do_ins;     // apply insert shift
        logic                   do_rem;     // apply remove shift
        logic                   do_rot;     // rotate occupied cells by one for dump
        logic [KEY_W-1:0]       new_key;
        logic [HANDLE_BITS-1:0] new_handle;
    } siq_ctrl_t;

endpackage

>>> rtl/core/siq_cell.sv
// One storage cell of the sorted chain: entry registers, mark and shift select.
module siq_cell
    import siq_pkg::*;
(
    input  logic                   clk,
    input  siq_ctrl_t              ctrl,
    input  logic                   occ,       // cell holds a live entry
    input  logic                   at_tail,   // first free cell
    input  logic                   at_last,   // last live cell
    input  logic                   carry_in,  // a mark was seen further up the chain
    output logic                   carry_out,
    input  logic [KEY_W-1:0]       left_key,
    input  logic [HANDLE_BITS-1:0] left_handle,
    input  logic [KEY_W-1:0]       right_key,
    input  logic [HANDLE_BITS-1:0] right_handle,
    input  logic [KEY_W-1:0]       head_key,
    input  logic [HANDLE_BITS-1:0] head_handle,
    output logic [KEY_W-1:0]       key,
    output logic [HANDLE_BITS-1:0] handle
);

    logic [KEY_W-1:0]       key_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic                   mark_reg;
    logic                   mark_next;
    logic                   key_hit;

    always_comb
    begin
        // insert goes ahead of the first entry >= new key (<= when descending)
        if (ctrl.desc)
            key_hit = ($signed(ctrl.new_key) >= $signed(key_reg));
        else
            key_hit = ($signed(key_reg) >= $signed(ctrl.new_key));
        if (ctrl.cap_insert)
            mark_next = (occ && key_hit) || at_tail;
        else
            mark_next = occ && (handle_reg == ctrl.new_handle);
    end

    assign carry_out = carry_in | mark_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
            mark_reg <= mark_next;

        if (ctrl.do_ins)
        begin
            if (carry_in)
            begin
                key_reg    <= left_key;
                handle_reg <= left_handle;
            end
            else if (mark_reg)
            begin
                key_reg    <= ctrl.new_key;
                handle_reg <= ctrl.new_handle;
            end
        end
        else if (ctrl.do_rem)
        begin
            if (carry_out)
            begin
                key_reg    <= right_key;
                handle_reg <= right_handle;
            end
        end
        else if (ctrl.do_rot)
        begin
            if (at_last)
            begin
                key_reg    <= head_key;
                handle_reg <= head_handle;
            end
            else
            begin
                key_reg    <= right_key;
                handle_reg <= right_handle;
            end
        end
    end

    assign key    = key_reg;
    assign handle = handle_reg;

endmodule

>>> rtl/core/sorted_insert_queue.sv
// Top level of the sorted insert queue: sequencer, cell chain and output register.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-------------------------------------
//  s_*       | in        | s_tvalid / s_tready  | tuser: operation; tdata: key, handle
//  m_*       | out       | m_tvalid / m_tready  | tuser: status, entry_valid; tdata:
//            |           |                      | key, handle; tlast: last
//  cfg_*     | in        | cfg_valid / cfg_ready| cfg_data: descending
//
//  Insert and remove: the accept cycle latches a compare mark in every cell, then
//  ST_APPLY, once the output register is free, resolves the first mark along the
//  chain and shifts. Dump emits one entry per cycle unless m_tready stalls it, by
//  rotating the occupied cells past the head; an empty list gives one empty result.
//  One item is in work at a time; the output register lets a result wait while
//  the next transaction is accepted. A stalled m_tready holds the sequencer.
//  Reset clears the entry count, the order register and the handshake state;
//  cell contents are not cleared and are only read below the entry count.
module sorted_insert_queue
    import siq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] operation
    input  logic [39:0] s_tdata,   // [31:0] entry_key, [39:32] entry_handle
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // [1:0] status, [2] entry_valid
    output logic [39:0] m_tdata,   // [31:0] out_key, [39:32] out_handle
    output logic        m_tlast,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // descending
);

    // sequencer state
    siq_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   desc_reg;
    logic [1:0]             op_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [HANDLE_BITS-1:0] handle_reg;

    // output register
    logic                   m_tvalid_reg;
    logic [1:0]             status_reg;
    logic                   ev_reg;
    logic [KEY_W-1:0]       out_key_reg;
    logic [HANDLE_W-1:0]    out_handle_reg;
    logic                   last_reg;

    logic                   load_out;
    logic [1:0]             status_next;
    logic                   ev_next;
    logic [KEY_W-1:0]       out_key_next;
    logic [HANDLE_W-1:0]    out_handle_next;
    logic                   last_next;

    logic                   s_accept;
    logic                   slot_free;
    logic                   list_full;
    logic                   found;
    logic                   dump_last;

    siq_ctrl_t              ctrl;
    logic                   do_ins, do_rem, do_rot;

    // chain wiring
    logic [KEY_W-1:0]       cell_key    [LIST_DEPTH];
    logic [HANDLE_BITS-1:0] cell_handle [LIST_DEPTH];
    logic [LIST_DEPTH:0]    carry;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign list_full = (cnt_reg == CNT_W'(LIST_DEPTH));
    assign found     = carry[LIST_DEPTH];
    assign dump_last = (idx_reg == cnt_reg - CNT_W'(1));

    // capture compares straight off the bus in the accept cycle
    always_comb
    begin
        ctrl.capture    = s_accept;
        ctrl.cap_insert = (s_tuser == OP_INSERT);
        ctrl.desc       = desc_reg;
        ctrl.do_ins     = do_ins;
        ctrl.do_rem     = do_rem;
        ctrl.do_rot     = do_rot;
        ctrl.new_key    = s_accept ? s_tdata[31:0] : key_reg;
        ctrl.new_handle = s_accept ? HANDLE_BITS'(s_tdata[39:32]) : handle_reg;
    end

    assign carry[0] = 1'b0;

    generate
        for (genvar i = 0; i < LIST_DEPTH; i++)
        begin : g_cell
            logic [KEY_W-1:0]       l_key, r_key;
            logic [HANDLE_BITS-1:0] l_handle, r_handle;

            if (i == 0)
            begin : g_first
                assign l_key    = ctrl.new_key;
                assign l_handle = ctrl.new_handle;
            end
            else
            begin : g_mid_l
                assign l_key    = cell_key[i-1];
                assign l_handle = cell_handle[i-1];
            end

            if (i == LIST_DEPTH - 1)
            begin : g_end
                assign r_key    = cell_key[i];
                assign r_handle = cell_handle[i];
            end
            else
            begin : g_mid_r
                assign r_key    = cell_key[i+1];
                assign r_handle = cell_handle[i+1];
            end

            siq_cell u_cell (
                .clk          (clk),
                .ctrl         (ctrl),
                .occ          (CNT_W'(i) < cnt_reg),
                .at_tail      (CNT_W'(i) == cnt_reg),
                .at_last      (CNT_W'(i + 1) == cnt_reg),
                .carry_in     (carry[i]),
                .carry_out    (carry[i+1]),
                .left_key     (l_key),
                .left_handle  (l_handle),
                .right_key    (r_key),
                .right_handle (r_handle),
                .head_key     (cell_key[0]),
                .head_handle  (cell_handle[0]),
                .key          (cell_key[i]),
                .handle       (cell_handle[i])
            );
        end
    endgenerate

    // sequencer: next state, chain control and result
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        do_ins          = 1'b0;
        do_rem          = 1'b0;
        do_rot          = 1'b0;
        load_out        = 1'b0;
        status_next     = STAT_OK;
        ev_next         = 1'b0;
        out_key_next    = '0;
        out_handle_next = '0;
        last_next       = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    idx_next = '0;
                    if (s_tuser == OP_DUMP)
                        state_next = ST_DUMP;
                    else
                        state_next = ST_APPLY;
                end
            end

            ST_APPLY:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (list_full)
                                status_next = STAT_FULL;
                            else
                            begin
                                do_ins   = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!found)
                                status_next = STAT_NOT_FOUND;
                            else
                            begin
                                do_rem   = 1'b1;
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end

            ST_DUMP:
            begin
                if (slot_free)
                begin
                    load_out = 1'b1;
                    if (cnt_reg == '0)
                        state_next = ST_IDLE;
                    else
                    begin
                        do_rot          = 1'b1;
                        ev_next         = 1'b1;
                        out_key_next    = cell_key[0];
                        out_handle_next = HANDLE_W'(cell_handle[0]);
                        last_next       = dump_last;
                        idx_next        = idx_reg + CNT_W'(1);
                        if (dump_last)
                            state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            desc_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready)
                desc_reg <= cfg_data;
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg     <= s_tuser;
            key_reg    <= s_tdata[31:0];
            handle_reg <= HANDLE_BITS'(s_tdata[39:32]);
        end
        if (load_out)
        begin
            status_reg     <= status_next;
            ev_reg         <= ev_next;
            out_key_reg    <= out_key_next;
            out_handle_reg <= out_handle_next;
            last_reg       <= last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {ev_reg, status_reg};
    assign m_tdata  = {out_handle_reg, out_key_reg};
    assign m_tlast  = last_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(LIST_DEPTH))
        else $error("entry count beyond list depth");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY && slot_free && op_reg == OP_INSERT && !list_full)
        |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    a_rem_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY && op_reg == OP_REMOVE && !found) |=> $stable(cnt_reg))
        else $error("missed remove changed the list");

    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP && slot_free && cnt_reg != '0 && dump_last)
        |=> state_reg == ST_IDLE && m_tvalid && m_tlast)
        else $error("dump did not close with a last transaction");

endmodule
